// File: rtl/core/ultrasonic_echo_ranger_core_defines.svh
// Assertion helpers for the ranger core. Sampled on clk_i, off during reset.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

// Same-cycle implication.
`define UER_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UER_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/uer_pkg.sv
package uer_pkg;

  localparam int CFG_W      = 20;
  localparam int TRIG_W     = 8;
  localparam int UPC_W      = 8;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_BITS_DEF = 20;

  localparam logic [CFG_W-1:0]  HOLDOFF_RST = 20'd200000;
  localparam logic [TRIG_W-1:0] TRIGGER_RST = 8'd10;
  localparam logic [CFG_W-1:0]  TIMEOUT_RST = 20'd304000;
  localparam logic [UPC_W-1:0]  UPC_RST     = 8'd58;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HOLD    = 3'd1,
    PH_TRIG_HI = 3'd2,
    PH_TRIG_LO = 3'd3,
    PH_WAIT    = 3'd4,
    PH_MEAS    = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLDOFF   = 2'd0,
    CFG_TRIGGER   = 2'd1,
    CFG_TIMEOUT   = 2'd2,
    CFG_US_PER_CM = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]  holdoff_us;
    logic [TRIG_W-1:0] trigger_us;
    logic [CFG_W-1:0]  timeout_us;
    logic [UPC_W-1:0]  us_per_cm;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
  } res_t;

endpackage

// File: rtl/core/uer_cfg.sv
module uer_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0] index_i,
  input  logic [uer_pkg::CFG_W-1:0]     data_i,
  output uer_pkg::cfg_t                 cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (cfg_idx_e'(index_i))
        CFG_HOLDOFF:   cfg_d.holdoff_us = data_i;
        CFG_TRIGGER:   cfg_d.trigger_us = data_i[TRIG_W-1:0];
        CFG_TIMEOUT:   cfg_d.timeout_us = data_i;
        CFG_US_PER_CM: cfg_d.us_per_cm  = data_i[UPC_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.holdoff_us <= HOLDOFF_RST;
      cfg_q.trigger_us <= TRIGGER_RST;
      cfg_q.timeout_us <= TIMEOUT_RST;
      cfg_q.us_per_cm  <= UPC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/uer_ctrl.sv
module uer_ctrl #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          cmd_i,
  input  logic          echo_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);
  import uer_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [DIST_W-1:0]     CM_MAX  = {DIST_W{1'b1}};

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] us_count_q, us_count_d;
  logic [UPC_W-1:0]      sub_q, sub_d;
  logic [DIST_W-1:0]     cm_q, cm_d;
  logic [DIST_W-1:0]     last_q, last_d;
  logic                  done, tmo;

  logic [COUNT_BITS-1:0] cnt_base, cnt_inc;
  logic [UPC_W-1:0]      sub_base, sub_inc, sub_next;
  logic [DIST_W-1:0]     cm_base, cm_next;
  logic [CMP_W-1:0]      limit;
  logic                  reach;

  always_comb begin
    cnt_base = (phase_q == PH_WAIT) ? '0 : us_count_q;
    sub_base = (phase_q == PH_WAIT) ? '0 : sub_q;
    cm_base  = (phase_q == PH_WAIT) ? '0 : cm_q;
    cnt_inc  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
    sub_inc  = sub_base + 1'b1;
    if (sub_inc >= cfg_i.us_per_cm) begin
      sub_next = '0;
      cm_next  = (cm_base == CM_MAX) ? cm_base : cm_base + 1'b1;
    end else begin
      sub_next = sub_inc;
      cm_next  = cm_base;
    end
    case (phase_q)
      PH_HOLD:               limit = CMP_W'(cfg_i.holdoff_us);
      PH_TRIG_HI, PH_TRIG_LO: limit = CMP_W'(cfg_i.trigger_us);
      default:               limit = CMP_W'(cfg_i.timeout_us);
    endcase
    reach = (CMP_W'(cnt_inc) >= limit) || (cnt_inc == CNT_MAX);
  end

  always_comb begin
    phase_d    = phase_q;
    us_count_d = us_count_q;
    sub_d      = sub_q;
    cm_d       = cm_q;
    last_d     = last_q;
    done       = 1'b0;
    tmo        = 1'b0;
    case (phase_q)
      PH_HOLD: begin
        us_count_d = reach ? '0 : cnt_inc;
        if (reach) phase_d = PH_TRIG_HI;
      end
      PH_TRIG_HI: begin
        us_count_d = reach ? '0 : cnt_inc;
        if (reach) phase_d = PH_TRIG_LO;
      end
      PH_TRIG_LO: begin
        us_count_d = reach ? '0 : cnt_inc;
        if (reach) phase_d = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo_i) begin
          phase_d    = PH_MEAS;
          us_count_d = cnt_inc;
          sub_d      = sub_next;
          cm_d       = cm_next;
          tmo        = reach;
        end
      end
      PH_MEAS: begin
        if (!echo_i) begin
          last_d  = cm_q;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          us_count_d = cnt_inc;
          sub_d      = sub_next;
          cm_d       = cm_next;
          tmo        = reach;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (cmd_i) begin
          phase_d    = PH_HOLD;
          us_count_d = '0;
        end
      end
    endcase
    if (tmo) begin
      last_d  = '0;
      done    = 1'b1;
      phase_d = PH_IDLE;
    end
  end

  always_comb begin
    res_o.trigger     = (phase_d == PH_TRIG_HI);
    res_o.busy        = (phase_d != PH_IDLE);
    res_o.done        = done;
    res_o.timed_out   = tmo;
    res_o.distance_cm = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      us_count_q <= '0;
      sub_q      <= '0;
      cm_q       <= '0;
      last_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      us_count_q <= us_count_d;
      sub_q      <= sub_d;
      cm_q       <= cm_d;
      last_q     <= last_d;
    end
  end

endmodule

// File: rtl/core/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranger. One input item per microsecond tick: cmd_i starts a
// measurement when idle, echo_i is the sampled echo level. Each input item
// yields exactly one result item: trigger level, busy, a done pulse, the
// timeout flag and the held distance in centimetres.
// Configuration must be written over cfg_valid_i/cfg_index_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this.
// cfg_ready_o is always high. Index 0 holdoff, 1 trigger width, 2 echo
// timeout, 3 microseconds per centimetre.
// An accepted input item is loaded into the input register; after one pass
// of the sequencer logic its result is loaded into the output register.
// Throughput: one item per cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register and one
// more item is taken into the input register; in_ready_o then drops until
// the result is taken.
// Reset clears the sequencer to idle, all counters and the held distance to
// zero, and loads the configuration defaults; no item is pending after reset.
module ultrasonic_echo_ranger_core #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic                          echo_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trigger_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          timed_out_o,
  output logic [uer_pkg::DIST_W-1:0]    distance_cm_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [uer_pkg::CFG_W-1:0]     cfg_data_i
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res, res_q;
  logic in_valid_q, out_valid_q;
  logic cmd_q, echo_q;
  logic step;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;

  uer_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  uer_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd_q),
    .echo_i (echo_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      echo_q <= echo_i;
    end
    if (step) res_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign trigger_o     = res_q.trigger;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign timed_out_o   = res_q.timed_out;
  assign distance_cm_o = res_q.distance_cm;

`include "ultrasonic_echo_ranger_core_defines.svh"

  `UER_ASSERT_IMP(a_stall_only, !in_ready_o, out_valid_o && !out_ready_i, "ready low without stall")
  `UER_ASSERT_IMP(a_tmo_zero, out_valid_o && timed_out_o, done_res_o && (distance_cm_o == '0), "timeout result malformed")
  `UER_ASSERT_IMP(a_done_idle, out_valid_o && done_res_o, !busy_res_o && !trigger_o, "done while busy")
  `UER_ASSERT_NXT(a_step_out, step, out_valid_o, "result lost after step")

endmodule

// File: verif/ultrasonic_echo_ranger_core_tb.sv
module ultrasonic_echo_ranger_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int COUNT_W     = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_OFF_CYCLES = 300;

  class ranger_scoreboard;
    logic [CFG_W-1:0]   holdoff;
    logic [TRIG_W-1:0]  trig;
    logic [CFG_W-1:0]   timeout;
    logic [UPC_W-1:0]   upc;
    phase_e             phase;
    logic [COUNT_W-1:0] us_cnt;
    logic [7:0]         cm_sub;
    logic [DIST_W-1:0]  cm_cnt;
    logic [DIST_W-1:0]  last_dist;
    res_t               pending[$];
    int                 errors;

    function new();
      holdoff   = HOLDOFF_RST;
      trig      = TRIGGER_RST;
      timeout   = TIMEOUT_RST;
      upc       = UPC_RST;
      phase     = PH_IDLE;
      us_cnt    = '0;
      cm_sub    = '0;
      cm_cnt    = '0;
      last_dist = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_HOLDOFF:   holdoff = val;
        CFG_TRIGGER:   trig = val[TRIG_W-1:0];
        CFG_TIMEOUT:   timeout = val;
        CFG_US_PER_CM: upc = val[UPC_W-1:0];
        default: ;
      endcase
    endfunction

    function bit tick_reaches(logic [CFG_W-1:0] lim);
      if (us_cnt != '1) us_cnt++;
      return (us_cnt >= lim) || (us_cnt == '1);
    endfunction

    function bit count_high();
      cm_sub = cm_sub + 8'd1;
      if (cm_sub >= upc) begin
        cm_sub = '0;
        if (cm_cnt != '1) cm_cnt++;
      end
      return tick_reaches(timeout);
    endfunction

    function void note_tick(logic cmd, logic echo);
      bit   done;
      bit   tmo;
      res_t r;
      done = 1'b0;
      tmo  = 1'b0;
      case (phase)
        PH_HOLD: begin
          if (tick_reaches(holdoff)) begin
            phase  = PH_TRIG_HI;
            us_cnt = '0;
          end
        end
        PH_TRIG_HI: begin
          if (tick_reaches(CFG_W'(trig))) begin
            phase  = PH_TRIG_LO;
            us_cnt = '0;
          end
        end
        PH_TRIG_LO: begin
          if (tick_reaches(CFG_W'(trig))) begin
            phase  = PH_WAIT;
            us_cnt = '0;
          end
        end
        PH_WAIT: begin
          if (echo) begin
            us_cnt = '0;
            cm_sub = '0;
            cm_cnt = '0;
            phase  = PH_MEAS;
            if (count_high()) tmo = 1'b1;
          end
        end
        PH_MEAS: begin
          if (!echo) begin
            last_dist = cm_cnt;
            done      = 1'b1;
            phase     = PH_IDLE;
          end else if (count_high()) begin
            tmo = 1'b1;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (cmd) begin
            phase  = PH_HOLD;
            us_cnt = '0;
          end
        end
      endcase
      if (tmo) begin
        last_dist = '0;
        done      = 1'b1;
        phase     = PH_IDLE;
      end
      r.trigger     = (phase == PH_TRIG_HI);
      r.busy        = (phase != PH_IDLE);
      r.done        = done;
      r.timed_out   = tmo;
      r.distance_cm = last_dist;
      pending.push_back(r);
    endfunction

    function void flag(string what, res_t want, res_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s: expected trig=%0b busy=%0b done=%0b tmo=%0b dist=%0d",
                 what, want.trigger, want.busy, want.done, want.timed_out, want.distance_cm);
        $display("  got trig=%0b busy=%0b done=%0b tmo=%0b dist=%0d",
                 got.trigger, got.busy, got.done, got.timed_out, got.distance_cm);
      end
    endfunction

    function void check_reading(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        flag("unexpected reading", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.trigger !== want.trigger || got.busy !== want.busy ||
          got.done !== want.done || got.timed_out !== want.timed_out ||
          got.distance_cm !== want.distance_cm) begin
        flag("reading mismatch", want, got);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 cmd_i = 1'b0;
  logic                 echo_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 trigger_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic                 timed_out_o;
  logic [DIST_W-1:0]    distance_cm_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  ranger_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int tx_pct[3] = '{35, 59, 0};
  int rx_pct[3] = '{59, 35, 0};
  int rx_hold_left = 0;
  int hold_offs_asked = 0;
  int hold_offs_done = 0;
  int cycles = 0;
  int ticks_sent = 0;

  ultrasonic_echo_ranger_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .echo_i        (echo_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trigger_o     (trigger_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .timed_out_o   (timed_out_o),
    .distance_cm_o (distance_cm_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold off the receiver for a long stretch on request, else stall at random
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_offs_done != hold_offs_asked) begin
      out_ready_i    <= 1'b0;
      rx_hold_left   <= HOLD_OFF_CYCLES;
      hold_offs_done <= hold_offs_asked;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_reading({trigger_o, busy_res_o, done_res_o, timed_out_o, distance_cm_o});
    end
  end

  task automatic send_tick(input logic cmd, input logic echo);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    echo_i     <= echo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(cmd, echo);
    ticks_sent++;
  endtask

  // finish any sequence in flight, then drain all readings
  task automatic settle();
    while (sb.phase != PH_IDLE) send_tick(1'b0, sb.phase == PH_WAIT);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] trig,
                              input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] upc);
    logic [CFG_W-1:0] vals[4];
    vals = '{hold, trig, tmo, upc};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // start, ride out holdoff and trigger, then echo high for width ticks
  task automatic range_once(input int wait_len, input int width);
    int lead;
    lead = (sb.holdoff == 0 ? 1 : int'(sb.holdoff)) + 2 * (sb.trig == 0 ? 1 : int'(sb.trig));
    send_tick(1'b1, 1'($urandom));
    repeat (lead) send_tick(1'($urandom_range(3) == 0), 1'($urandom));
    repeat (wait_len) send_tick(1'($urandom), 1'b0);
    repeat (width) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic sweep(input int n);
    int stop;
    stop = ticks_sent + n;
    while (ticks_sent < stop) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom), 1'($urandom));
      end else begin
        range_once($urandom_range(0, 6),
                   ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] tmo_pick;
    logic [UPC_W-1:0] upc_pick;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle();
    program_regs(20'd0, 20'd1, 20'd3, 20'd1);
    range_once(1, 2);
    range_once(0, 5);
    settle();
    program_regs(20'd0, 20'd0, 20'd0, 20'd0);
    range_once(0, 1);

    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = tx_pct[m];
      rx_idle_pct = rx_pct[m];
      repeat (2) begin
        settle();
        case ($urandom_range(2))
          0: tmo_pick = CFG_W'($urandom_range(0, 12));
          1: tmo_pick = CFG_W'($urandom_range(13, 60));
          default: tmo_pick = CFG_W'($urandom_range(61, 20'hFFFFF));
        endcase
        upc_pick = ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom_range(0, 9));
        program_regs(CFG_W'($urandom_range(0, 8)), {12'($urandom), 8'($urandom_range(0, 4))},
                     tmo_pick, {12'($urandom), upc_pick});
        if (m == 2) hold_offs_asked++;
        sweep(40);
      end
    end

    settle();
    program_regs(20'hFFFFF, 20'hFF, 20'hFFFFF, 20'hFF);
    repeat (6) send_tick(1'b0, 1'($urandom));
    settle();
    program_regs(20'd3, 20'd2, 20'hFFFFF, 20'hFF);
    range_once(2, 260);

    settle();
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
